@@ rtl/sbrp_pkg.sv @@
// shared types and constants for the stun binding response parser
package sbrp_pkg;

  localparam int MAX_DATAGRAM_BYTES_DEF = 512;
  localparam int HEADER_BYTES = 20;
  localparam int START_W = 18;

  localparam logic [31:0] MAGIC_COOKIE = 32'h2112A442;
  localparam logic [15:0] BINDING_SUCCESS = 16'h0101;
  localparam logic [15:0] ATTR_MAPPED = 16'h0001;
  localparam logic [15:0] ATTR_XOR_MAPPED = 16'h0020;
  localparam logic [7:0] FAMILY_V4 = 8'h01;
  localparam logic [7:0] FAMILY_V6 = 8'h02;

  typedef enum logic [2:0] {
    STATUS_V4     = 3'd0,
    STATUS_V6     = 3'd1,
    STATUS_HEADER = 3'd2,
    STATUS_ID     = 3'd3,
    STATUS_NONE   = 3'd4
  } status_t;

  typedef enum logic {
    REG_TXID_UPPER = 1'b0,
    REG_TXID_LOWER = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_datagram;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] mapped_port;
    logic [63:0] address_upper;
    logic [63:0] address_lower;
  } out_item_t;

endpackage

@@ rtl/stun_binding_response_parser_core.sv @@
// stun binding response parser: header check, attribute walk and mapped address capture
// Takes one datagram byte per cycle and gives one result per datagram, on its flagged last
// byte: status, port and binary address from the first usable MAPPED-ADDRESS or
// XOR-MAPPED-ADDRESS, with the cookie and transaction id XOR removed. Each byte is held in
// the input register and is parsed on the way into the parser state; the result is loaded
// into the result register with the last byte. The throughput is one byte per cycle;
// a last byte waits in the input register only while the previous result is still held in
// the result register and not taken. Bytes beyond MAX_DATAGRAM_BYTES are dropped but their
// end flag still closes the datagram. The transaction id is set through the APB port:
// txid_upper at address 0, txid_lower at address 8.
module stun_binding_response_parser_core #(
  parameter int MAX_DATAGRAM_BYTES = sbrp_pkg::MAX_DATAGRAM_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sbrp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sbrp_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import sbrp_pkg::*;

  localparam int POS_W = $clog2(MAX_DATAGRAM_BYTES + 1);

  // configuration
  logic [31:0] txid_upper;
  logic [63:0] txid_lower;

  // input register
  logic     s1_valid;
  in_item_t s1_item;
  logic     s1_advance;
  logic     s1_fire;

  // parser state
  logic [POS_W-1:0]   pos, pos_next;
  logic [15:0]        header_type, header_type_next;
  logic [15:0]        declared_length, declared_length_next;
  logic               id_matches, id_matches_next;
  logic [15:0]        walk_remaining, walk_remaining_next;
  logic               walk_stopped, walk_stopped_next;
  logic [START_W-1:0] attr_start, attr_start_next;
  logic [15:0]        attr_kind, attr_kind_next;
  logic [15:0]        attr_size, attr_size_next;
  logic [7:0]         cand_family, cand_family_next;
  logic [15:0]        cand_port, cand_port_next;
  logic [63:0]        cand_hi, cand_hi_next;
  logic [63:0]        cand_lo, cand_lo_next;
  logic               found_flag, found_flag_next;
  logic               found_v6, found_v6_next;
  logic [15:0]        found_port, found_port_next;
  logic [63:0]        found_hi, found_hi_next;
  logic [63:0]        found_lo, found_lo_next;

  out_item_t result;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      txid_upper <= '0;
      txid_lower <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_index_t'(paddr[3]))
        REG_TXID_UPPER: txid_upper <= pwdata[31:0];
        REG_TXID_LOWER: txid_lower <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index_t'(paddr[3]))
      REG_TXID_UPPER: prdata = {32'h0, txid_upper};
      REG_TXID_LOWER: prdata = txid_lower;
      default:        prdata = '0;
    endcase
  end

  // a last byte needs room in the result register
  assign s1_advance = !s1_item.end_of_datagram || !out_valid || out_ready;
  assign s1_fire    = s1_valid && s1_advance;
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  // byte parse
  always_comb begin
    logic [7:0]         b;
    logic [95:0]        id_all;
    logic [3:0]         id_sel;
    logic [7:0]         want;
    logic [START_W-1:0] pos_w;
    logic [START_W-1:0] r;
    logic [START_W-1:0] v;
    logic [2:0]         k;
    logic               stop_now;
    logic               is_xor;
    logic [15:0]        port_dec;
    logic [31:0]        v4_addr;
    logic               captured;
    logic [16:0]        size_round;
    logic [START_W-1:0] step;
    logic [16:0]        len_need;

    pos_next             = pos;
    header_type_next     = header_type;
    declared_length_next = declared_length;
    id_matches_next      = id_matches;
    walk_remaining_next  = walk_remaining;
    walk_stopped_next    = walk_stopped;
    attr_start_next      = attr_start;
    attr_kind_next       = attr_kind;
    attr_size_next       = attr_size;
    cand_family_next     = cand_family;
    cand_port_next       = cand_port;
    cand_hi_next         = cand_hi;
    cand_lo_next         = cand_lo;
    found_flag_next      = found_flag;
    found_v6_next        = found_v6;
    found_port_next      = found_port;
    found_hi_next        = found_hi;
    found_lo_next        = found_lo;

    b          = s1_item.rx_byte;
    id_all     = {txid_upper, txid_lower};
    id_sel     = 4'd11 - (4'(pos) - 4'd8);
    want       = id_all[{id_sel, 3'b000} +: 8];
    pos_w      = START_W'(pos);
    r          = pos_w - attr_start;
    v          = r - START_W'(4);
    k          = v[2:0] - 3'd4;
    stop_now   = 1'b0;
    is_xor     = 1'b0;
    port_dec   = '0;
    v4_addr    = '0;
    captured   = 1'b0;
    size_round = '0;
    step       = '0;

    if (pos < POS_W'(MAX_DATAGRAM_BYTES)) begin
      pos_next = pos + POS_W'(1);

      // fixed header
      priority if (pos == POS_W'(0)) begin
        header_type_next = {b, 8'h00};
      end else if (pos == POS_W'(1)) begin
        header_type_next = {header_type[15:8], b};
      end else if (pos == POS_W'(2)) begin
        declared_length_next = {b, 8'h00};
      end else if (pos == POS_W'(3)) begin
        declared_length_next = {declared_length[15:8], b};
        walk_remaining_next  = {declared_length[15:8], b};
      end else if (pos >= POS_W'(8) && pos < POS_W'(HEADER_BYTES)) begin
        if (want != b) begin
          id_matches_next = 1'b0;
        end
      end else begin
      end

      // attribute walk
      if (!walk_stopped && pos >= POS_W'(HEADER_BYTES) && pos_w >= attr_start) begin
        priority if (r == START_W'(0)) begin
          if (walk_remaining < 16'd4) begin
            stop_now = 1'b1;
          end else begin
            cand_family_next = '0;
            cand_port_next   = '0;
            cand_hi_next     = '0;
            cand_lo_next     = '0;
            attr_kind_next   = {b, 8'h00};
          end
        end else if (r == START_W'(1)) begin
          attr_kind_next = {attr_kind[15:8], b};
        end else if (r == START_W'(2)) begin
          attr_size_next = {b, 8'h00};
        end else if (r == START_W'(3)) begin
          attr_size_next = {attr_size[15:8], b};
          if ({attr_size[15:8], b} > walk_remaining) begin
            stop_now = 1'b1;
          end
        end else begin
          priority if (v == START_W'(1)) begin
            cand_family_next = b;
          end else if (v == START_W'(2)) begin
            cand_port_next = {b, 8'h00};
          end else if (v == START_W'(3)) begin
            cand_port_next = {cand_port[15:8], b};
          end else if (v >= START_W'(4) && v < START_W'(12)) begin
            cand_hi_next[{~k, 3'b000} +: 8] = cand_hi[{~k, 3'b000} +: 8] | b;
          end else if (v >= START_W'(12) && v < START_W'(20)) begin
            cand_lo_next[{~k, 3'b000} +: 8] = cand_lo[{~k, 3'b000} +: 8] | b;
          end else begin
          end
        end

        if (stop_now) begin
          walk_stopped_next = 1'b1;
        end else if (r >= START_W'(3) && r == START_W'(attr_size_next) + START_W'(3)) begin
          // attribute complete
          is_xor   = (attr_kind_next == ATTR_XOR_MAPPED);
          port_dec = cand_port_next ^ (is_xor ? MAGIC_COOKIE[31:16] : 16'h0000);
          v4_addr  = cand_hi_next[63:32] ^ (is_xor ? MAGIC_COOKIE : 32'h0);
          if ((attr_kind_next == ATTR_MAPPED || is_xor) && attr_size_next >= 16'd4) begin
            if (cand_family_next == FAMILY_V4 && attr_size_next >= 16'd8) begin
              captured        = 1'b1;
              found_v6_next   = 1'b0;
              found_hi_next   = '0;
              found_lo_next   = {32'h0, v4_addr};
            end else if (cand_family_next == FAMILY_V6 && attr_size_next >= 16'd20) begin
              captured        = 1'b1;
              found_v6_next   = 1'b1;
              found_hi_next   = cand_hi_next ^ (is_xor ? {MAGIC_COOKIE, txid_upper} : 64'h0);
              found_lo_next   = cand_lo_next ^ (is_xor ? txid_lower : 64'h0);
            end
          end
          if (captured) begin
            found_flag_next   = 1'b1;
            found_port_next   = port_dec;
            walk_stopped_next = 1'b1;
          end else begin
            size_round      = {1'b0, attr_size_next} + 17'd3;
            step            = START_W'({size_round[16:2], 2'b00}) + START_W'(4);
            attr_start_next = attr_start + step;
            if (START_W'(walk_remaining) < step) begin
              walk_stopped_next = 1'b1;
            end else begin
              walk_remaining_next = walk_remaining - step[15:0];
            end
          end
        end
      end
    end

    // result from the state after this byte
    len_need = 17'(declared_length_next) + 17'(HEADER_BYTES);
    result   = '{status: STATUS_NONE, mapped_port: '0, address_upper: '0, address_lower: '0};
    priority if (pos_next < POS_W'(HEADER_BYTES) || header_type_next != BINDING_SUCCESS ||
                 17'(pos_next) < len_need) begin
      result.status = STATUS_HEADER;
    end else if (!id_matches_next) begin
      result.status = STATUS_ID;
    end else if (found_flag_next) begin
      result.status        = found_v6_next ? STATUS_V6 : STATUS_V4;
      result.mapped_port   = found_port_next;
      result.address_upper = found_hi_next;
      result.address_lower = found_lo_next;
    end else begin
      result.status = STATUS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_fire && s1_item.end_of_datagram)) begin
      pos             <= '0;
      header_type     <= '0;
      declared_length <= '0;
      id_matches      <= 1'b1;
      walk_remaining  <= '0;
      walk_stopped    <= 1'b0;
      attr_start      <= START_W'(HEADER_BYTES);
      attr_kind       <= '0;
      attr_size       <= '0;
      cand_family     <= '0;
      cand_port       <= '0;
      cand_hi         <= '0;
      cand_lo         <= '0;
      found_flag      <= 1'b0;
      found_v6        <= 1'b0;
      found_port      <= '0;
      found_hi        <= '0;
      found_lo        <= '0;
    end else if (s1_fire) begin
      pos             <= pos_next;
      header_type     <= header_type_next;
      declared_length <= declared_length_next;
      id_matches      <= id_matches_next;
      walk_remaining  <= walk_remaining_next;
      walk_stopped    <= walk_stopped_next;
      attr_start      <= attr_start_next;
      attr_kind       <= attr_kind_next;
      attr_size       <= attr_size_next;
      cand_family     <= cand_family_next;
      cand_port       <= cand_port_next;
      cand_hi         <= cand_hi_next;
      cand_lo         <= cand_lo_next;
      found_flag      <= found_flag_next;
      found_v6        <= found_v6_next;
      found_port      <= found_port_next;
      found_hi        <= found_hi_next;
      found_lo        <= found_lo_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_item.end_of_datagram) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_item.end_of_datagram) begin
      out_data <= result;
    end
  end

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_item.end_of_datagram |=> out_valid)
    else $error("last byte did not load a result");

  a_pos_bounded: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(MAX_DATAGRAM_BYTES))
    else $error("byte position past the datagram limit");

  a_no_find_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STATUS_V4 && out_data.status != STATUS_V6 |->
      out_data.mapped_port == 16'h0 && out_data.address_upper == 64'h0 &&
      out_data.address_lower == 64'h0)
    else $error("address fields set without a found address");

  a_v4_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STATUS_V4 |->
      out_data.address_upper == 64'h0 && out_data.address_lower[63:32] == 32'h0)
    else $error("ipv4 result carries upper address bits");

  a_stall_holds_last: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_item.end_of_datagram && out_valid && !out_ready |=> s1_valid)
    else $error("last byte dropped while result register full");

endmodule
